/* hw/rtl/intercept_aim_point_top_macros.svh */
// Assertion macros for the intercept aim point block
`ifndef INTERCEPT_AIM_POINT_TOP_MACROS_SVH
`define INTERCEPT_AIM_POINT_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define IAP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define IAP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/iap_pkg.sv */
// Shared constants and pipeline sideband types for the intercept aim point block
package iap_pkg;

    localparam int SQRT_STEPS = 64;
    localparam int DIV_STEPS  = 35;
    localparam logic [DIV_STEPS-1:0] OFFSET_CAP = 35'h4_0000_0000;

    // Clamp edge register indexes
    localparam logic [1:0] CFG_LEFT   = 2'd0;
    localparam logic [1:0] CFG_TOP    = 2'd1;
    localparam logic [1:0] CFG_RIGHT  = 2'd2;
    localparam logic [1:0] CFG_BOTTOM = 2'd3;

    // Carried alongside the square root
    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic               vx_neg;
        logic               vy_neg;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic [61:0]        t;
        logic [63:0]        bm;
        logic               bneg;
        logic               bypass;
    } sqrt_sb_t;

    // Carried alongside the divider
    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic               vx_neg;
        logic               vy_neg;
        logic               sat_x;
        logic               sat_y;
        logic               bypass;
    } div_sb_t;

endpackage

/* hw/rtl/iap_front.sv */
// Front end: differences, squares, dot product and discriminant
module iap_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en_i,
    input  logic               valid_i,
    input  logic signed [31:0] origin_x_i,
    input  logic signed [31:0] origin_y_i,
    input  logic [30:0]        shot_speed_i,
    input  logic signed [31:0] target_x_i,
    input  logic signed [31:0] target_y_i,
    input  logic signed [31:0] target_vel_x_i,
    input  logic signed [31:0] target_vel_y_i,
    output logic               valid_o,
    output logic [127:0]       disc_o,
    output iap_pkg::sqrt_sb_t  sb_o
);
    import iap_pkg::*;

    // stage 0: differences and magnitudes
    logic [32:0] dx_next, dy_next;
    logic [31:0] s0_adx_reg, s0_ady_reg, s0_ax_reg, s0_ay_reg;
    logic        s0_sgnx_reg, s0_sgny_reg, s0_still_reg, s0_vxn_reg, s0_vyn_reg;
    logic [30:0] s0_s_reg;
    logic signed [31:0] s0_tx_reg, s0_ty_reg;
    logic        s0_valid_reg;

    assign dx_next = {target_x_i[31], target_x_i} - {origin_x_i[31], origin_x_i};
    assign dy_next = {target_y_i[31], target_y_i} - {origin_y_i[31], origin_y_i};

    always_ff @(posedge aclk) begin
        if (en_i) begin
            s0_adx_reg  <= dx_next[32] ? (~dx_next[31:0] + 32'd1) : dx_next[31:0];
            s0_ady_reg  <= dy_next[32] ? (~dy_next[31:0] + 32'd1) : dy_next[31:0];
            s0_ax_reg   <= target_vel_x_i[31] ? (~target_vel_x_i + 32'd1) : target_vel_x_i;
            s0_ay_reg   <= target_vel_y_i[31] ? (~target_vel_y_i + 32'd1) : target_vel_y_i;
            s0_sgnx_reg <= dx_next[32] ^ target_vel_x_i[31];
            s0_sgny_reg <= dy_next[32] ^ target_vel_y_i[31];
            s0_still_reg <= (target_vel_x_i == 32'sd0) && (target_vel_y_i == 32'sd0);
            s0_vxn_reg  <= target_vel_x_i[31];
            s0_vyn_reg  <= target_vel_y_i[31];
            s0_s_reg    <= shot_speed_i;
            s0_tx_reg   <= target_x_i;
            s0_ty_reg   <= target_y_i;
        end
    end

    // stage 1: products
    logic [63:0] s1_ax2_reg, s1_ay2_reg, s1_pxv_reg, s1_pyv_reg, s1_dxx_reg, s1_dyy_reg;
    logic [61:0] s1_s2_reg;
    logic [31:0] s1_ax_reg, s1_ay_reg;
    logic        s1_sgnx_reg, s1_sgny_reg, s1_still_reg, s1_vxn_reg, s1_vyn_reg;
    logic signed [31:0] s1_tx_reg, s1_ty_reg;
    logic        s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (en_i) begin
            s1_ax2_reg   <= s0_ax_reg * s0_ax_reg;
            s1_ay2_reg   <= s0_ay_reg * s0_ay_reg;
            s1_s2_reg    <= s0_s_reg * s0_s_reg;
            s1_pxv_reg   <= s0_adx_reg * s0_ax_reg;
            s1_pyv_reg   <= s0_ady_reg * s0_ay_reg;
            s1_dxx_reg   <= s0_adx_reg * s0_adx_reg;
            s1_dyy_reg   <= s0_ady_reg * s0_ady_reg;
            s1_ax_reg    <= s0_ax_reg;
            s1_ay_reg    <= s0_ay_reg;
            s1_sgnx_reg  <= s0_sgnx_reg;
            s1_sgny_reg  <= s0_sgny_reg;
            s1_still_reg <= s0_still_reg;
            s1_vxn_reg   <= s0_vxn_reg;
            s1_vyn_reg   <= s0_vyn_reg;
            s1_tx_reg    <= s0_tx_reg;
            s1_ty_reg    <= s0_ty_reg;
        end
    end

    // stage 2: sums
    logic [65:0] bx_next, by_next;
    logic [63:0] s2_v2_reg;
    logic [64:0] s2_d_reg;
    logic [65:0] s2_b_reg;
    logic [61:0] s2_s2_reg;
    logic [31:0] s2_ax_reg, s2_ay_reg;
    logic        s2_still_reg, s2_vxn_reg, s2_vyn_reg;
    logic signed [31:0] s2_tx_reg, s2_ty_reg;
    logic        s2_valid_reg;

    assign bx_next = s1_sgnx_reg ? (66'd0 - {2'b00, s1_pxv_reg}) : {2'b00, s1_pxv_reg};
    assign by_next = s1_sgny_reg ? (66'd0 - {2'b00, s1_pyv_reg}) : {2'b00, s1_pyv_reg};

    always_ff @(posedge aclk) begin
        if (en_i) begin
            s2_v2_reg    <= s1_ax2_reg + s1_ay2_reg;
            s2_d_reg     <= {1'b0, s1_dxx_reg} + {1'b0, s1_dyy_reg};
            s2_b_reg     <= bx_next + by_next;
            s2_s2_reg    <= s1_s2_reg;
            s2_ax_reg    <= s1_ax_reg;
            s2_ay_reg    <= s1_ay_reg;
            s2_still_reg <= s1_still_reg;
            s2_vxn_reg   <= s1_vxn_reg;
            s2_vyn_reg   <= s1_vyn_reg;
            s2_tx_reg    <= s1_tx_reg;
            s2_ty_reg    <= s1_ty_reg;
        end
    end

    // stage 3: pass-through decision, T and |b|
    sqrt_sb_t    s3_sb_reg;
    logic [64:0] s3_d_reg;
    logic        s3_valid_reg;

    always_ff @(posedge aclk) begin
        if (en_i) begin
            s3_sb_reg.tx     <= s2_tx_reg;
            s3_sb_reg.ty     <= s2_ty_reg;
            s3_sb_reg.vx_neg <= s2_vxn_reg;
            s3_sb_reg.vy_neg <= s2_vyn_reg;
            s3_sb_reg.ax     <= s2_ax_reg;
            s3_sb_reg.ay     <= s2_ay_reg;
            s3_sb_reg.t      <= s2_s2_reg - s2_v2_reg[61:0];
            s3_sb_reg.bm     <= s2_b_reg[65] ? (~s2_b_reg[63:0] + 64'd1) : s2_b_reg[63:0];
            s3_sb_reg.bneg   <= s2_b_reg[65];
            s3_sb_reg.bypass <= s2_still_reg || (s2_v2_reg >= {2'b00, s2_s2_reg});
            s3_d_reg         <= s2_d_reg;
        end
    end

    // stage 4: partial products of b^2 and T*|d|^2
    logic [63:0] s4_ll_reg, s4_lh_reg, s4_hh_reg, s4_p00_reg, s4_p01_reg;
    logic [61:0] s4_p10_reg, s4_p11_reg;
    logic        s4_d2_reg;
    sqrt_sb_t    s4_sb_reg;
    logic        s4_valid_reg;

    always_ff @(posedge aclk) begin
        if (en_i) begin
            s4_ll_reg  <= s3_sb_reg.bm[31:0] * s3_sb_reg.bm[31:0];
            s4_lh_reg  <= s3_sb_reg.bm[31:0] * s3_sb_reg.bm[63:32];
            s4_hh_reg  <= s3_sb_reg.bm[63:32] * s3_sb_reg.bm[63:32];
            s4_p00_reg <= s3_sb_reg.t[31:0] * s3_d_reg[31:0];
            s4_p01_reg <= s3_sb_reg.t[31:0] * s3_d_reg[63:32];
            s4_p10_reg <= s3_sb_reg.t[61:32] * s3_d_reg[31:0];
            s4_p11_reg <= s3_sb_reg.t[61:32] * s3_d_reg[63:32];
            s4_d2_reg  <= s3_d_reg[64];
            s4_sb_reg  <= s3_sb_reg;
        end
    end

    // stage 5: assemble the two terms
    logic [64:0]  mid_next;
    logic [127:0] s5_bm2_reg, s5_td_reg;
    sqrt_sb_t     s5_sb_reg;
    logic         s5_valid_reg;

    assign mid_next = {1'b0, s4_p01_reg} + {3'b000, s4_p10_reg};

    always_ff @(posedge aclk) begin
        if (en_i) begin
            s5_bm2_reg <= {s4_hh_reg, 64'd0} + {31'd0, s4_lh_reg, 33'd0} + {64'd0, s4_ll_reg};
            s5_td_reg  <= {2'b00, s4_p11_reg, 64'd0} + {31'd0, mid_next, 32'd0}
                        + {64'd0, s4_p00_reg}
                        + (s4_d2_reg ? {2'b00, s4_sb_reg.t, 64'd0} : 128'd0);
            s5_sb_reg  <= s4_sb_reg;
        end
    end

    // stage 6: discriminant
    logic [127:0] s6_disc_reg;
    sqrt_sb_t     s6_sb_reg;
    logic         s6_valid_reg;

    always_ff @(posedge aclk) begin
        if (en_i) begin
            s6_disc_reg <= s5_bm2_reg + s5_td_reg;
            s6_sb_reg   <= s5_sb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else if (en_i) begin
            s0_valid_reg <= valid_i;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    assign valid_o = s6_valid_reg;
    assign disc_o  = s6_disc_reg;
    assign sb_o    = s6_sb_reg;

endmodule

/* hw/rtl/iap_sqrt.sv */
// Pipelined floor square root, one root bit per stage
module iap_sqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en_i,
    input  logic              valid_i,
    input  logic [127:0]      disc_i,
    input  iap_pkg::sqrt_sb_t sb_i,
    output logic              valid_o,
    output logic [63:0]       root_o,
    output iap_pkg::sqrt_sb_t sb_o
);
    import iap_pkg::*;

    logic [65:0]            rem_reg  [SQRT_STEPS];
    logic [63:0]            root_reg [SQRT_STEPS];
    logic [127:0]           rad_reg  [SQRT_STEPS];
    sqrt_sb_t               sb_reg   [SQRT_STEPS];
    logic [SQRT_STEPS-1:0]  valid_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [65:0]  rem_in;
        logic [63:0]  root_in;
        logic [127:0] rad_in;
        sqrt_sb_t     sb_in;
        logic         valid_in;
        logic [67:0]  rem_sh, trial, diff;
        logic         take;

        if (k == 0) begin : g_first
            assign rem_in   = '0;
            assign root_in  = '0;
            assign rad_in   = disc_i;
            assign sb_in    = sb_i;
            assign valid_in = valid_i;
        end else begin : g_next
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign rad_in   = rad_reg[k-1];
            assign sb_in    = sb_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        // bring down the next two radicand bits and try a one
        assign rem_sh = {rem_in, rad_in[127:126]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign diff   = rem_sh - trial;
        assign take   = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (en_i) begin
                rem_reg[k]  <= take ? diff[65:0] : rem_sh[65:0];
                root_reg[k] <= {root_in[62:0], take};
                rad_reg[k]  <= {rad_in[125:0], 2'b00};
                sb_reg[k]   <= sb_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en_i) begin
                valid_reg[k] <= valid_in;
            end
        end
    end

    assign valid_o = valid_reg[SQRT_STEPS-1];
    assign root_o  = root_reg[SQRT_STEPS-1];
    assign sb_o    = sb_reg[SQRT_STEPS-1];

endmodule

/* hw/rtl/iap_div.sv */
// Two-lane pipelined restoring divider with a shared divisor, one quotient bit per stage
module iap_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en_i,
    input  logic                                valid_i,
    input  logic [1:0][96:0]                    num_i,
    input  logic [61:0]                         den_i,
    input  iap_pkg::div_sb_t                    sb_i,
    output logic                                valid_o,
    output logic [1:0][iap_pkg::DIV_STEPS-1:0]  quo_o,
    output iap_pkg::div_sb_t                    sb_o
);
    import iap_pkg::*;

    logic [1:0][61:0]           rem_reg [DIV_STEPS];
    logic [1:0][DIV_STEPS-1:0]  low_reg [DIV_STEPS];
    logic [1:0][DIV_STEPS-1:0]  quo_reg [DIV_STEPS];
    logic [61:0]                den_reg [DIV_STEPS];
    div_sb_t                    sb_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0]       valid_reg;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [1:0][61:0]          rem_in;
        logic [1:0][DIV_STEPS-1:0] low_in, quo_in;
        logic [61:0]               den_in;
        div_sb_t                   sb_in;
        logic                      valid_in;

        if (k == 0) begin : g_first
            // top bits start the remainder; the rest shift in one a stage
            assign rem_in[0] = num_i[0][96:DIV_STEPS];
            assign rem_in[1] = num_i[1][96:DIV_STEPS];
            assign low_in[0] = num_i[0][DIV_STEPS-1:0];
            assign low_in[1] = num_i[1][DIV_STEPS-1:0];
            assign quo_in    = '0;
            assign den_in    = den_i;
            assign sb_in     = sb_i;
            assign valid_in  = valid_i;
        end else begin : g_next
            assign rem_in   = rem_reg[k-1];
            assign low_in   = low_reg[k-1];
            assign quo_in   = quo_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign sb_in    = sb_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [62:0] rem_sh, diff;
            logic        take;

            assign rem_sh = {rem_in[l], low_in[l][DIV_STEPS-1]};
            assign diff   = rem_sh - {1'b0, den_in};
            assign take   = (rem_sh >= {1'b0, den_in});

            always_ff @(posedge aclk) begin
                if (en_i) begin
                    rem_reg[k][l] <= take ? diff[61:0] : rem_sh[61:0];
                    low_reg[k][l] <= {low_in[l][DIV_STEPS-2:0], 1'b0};
                    quo_reg[k][l] <= {quo_in[l][DIV_STEPS-2:0], take};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en_i) begin
                den_reg[k] <= den_in;
                sb_reg[k]  <= sb_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en_i) begin
                valid_reg[k] <= valid_in;
            end
        end
    end

    assign valid_o = valid_reg[DIV_STEPS-1];
    assign quo_o   = quo_reg[DIV_STEPS-1];
    assign sb_o    = sb_reg[DIV_STEPS-1];

endmodule

/* hw/rtl/intercept_aim_point_top.sv */
// Top level of the intercept aim point block: config registers, offset stages and output
//
// Input channel s_*: one query per transfer (shooter origin, shot speed, target
// position and velocity). Result channel m_*: one aim point per query, in query
// order, with m_solved low when the target position was passed through.
// Configuration: cfg_wr_en writes cfg_wdata to the clamp edge chosen by
// cfg_index in the same cycle; write only while no query is in flight.
// Register stages from the input to m_valid, in order: 7 front-end stages, 64
// square root stages (one root bit each), 4 offset stages, 35 divider stages
// (one quotient bit each), one saturate and add stage and the output register.
// Throughput is one query per cycle while s_ready is high; the square root and
// divider pipelines set the latency, and every stage accepts a new item each
// cycle that the pipeline advances.
// Reset clears every valid bit and loads the default clamp rectangle
// (left and top 0, right and bottom 0x7FFFFFFF).
// When the receiver stalls, the output register holds its result; the
// pipeline still advances into empty slots and freezes once its last stage
// is full, so s_ready drops only then.
module intercept_aim_point_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_origin_x,
    input  logic signed [31:0] s_origin_y,
    input  logic [30:0]        s_shot_speed,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_target_vel_x,
    input  logic signed [31:0] s_target_vel_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_aim_x,
    output logic signed [31:0] m_aim_y,
    output logic               m_solved
);
    import iap_pkg::*;

    `include "intercept_aim_point_top_macros.svh"

    localparam logic signed [31:0] BOUND_HIGH_RESET = 32'sh7FFF_FFFF;

    logic signed [31:0] bound_left_reg, bound_top_reg, bound_right_reg, bound_bottom_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_left_reg   <= 32'sd0;
            bound_top_reg    <= 32'sd0;
            bound_right_reg  <= BOUND_HIGH_RESET;
            bound_bottom_reg <= BOUND_HIGH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LEFT:   bound_left_reg   <= $signed(cfg_wdata);
                CFG_TOP:    bound_top_reg    <= $signed(cfg_wdata);
                CFG_RIGHT:  bound_right_reg  <= $signed(cfg_wdata);
                CFG_BOTTOM: bound_bottom_reg <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    // advance everything unless the last stage is full and the output cannot take it
    logic pipe_en;
    logic f1_valid_reg;
    logic m_valid_reg;

    assign pipe_en = !f1_valid_reg || !m_valid_reg || m_ready;
    assign s_ready = pipe_en;

    logic         fe_valid;
    logic [127:0] fe_disc;
    sqrt_sb_t     fe_sb;

    iap_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en_i           (pipe_en),
        .valid_i        (s_valid),
        .origin_x_i     (s_origin_x),
        .origin_y_i     (s_origin_y),
        .shot_speed_i   (s_shot_speed),
        .target_x_i     (s_target_x),
        .target_y_i     (s_target_y),
        .target_vel_x_i (s_target_vel_x),
        .target_vel_y_i (s_target_vel_y),
        .valid_o        (fe_valid),
        .disc_o         (fe_disc),
        .sb_o           (fe_sb)
    );

    logic        sq_valid;
    logic [63:0] sq_root;
    sqrt_sb_t    sq_sb;

    iap_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en_i    (pipe_en),
        .valid_i (fe_valid),
        .disc_i  (fe_disc),
        .sb_i    (fe_sb),
        .valid_o (sq_valid),
        .root_o  (sq_root),
        .sb_o    (sq_sb)
    );

    // P1: numerator b + root
    logic [64:0] p1_num_reg;
    sqrt_sb_t    p1_sb_reg;
    logic        p1_valid_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p1_num_reg <= sq_sb.bneg ? ({1'b0, sq_root} - {1'b0, sq_sb.bm})
                                     : ({1'b0, sq_root} + {1'b0, sq_sb.bm});
            p1_sb_reg  <= sq_sb;
        end
    end

    // P2: partial products of numerator by each velocity magnitude
    logic [63:0] p2_mx0_reg, p2_mx1_reg, p2_my0_reg, p2_my1_reg;
    logic        p2_n2_reg;
    sqrt_sb_t    p2_sb_reg;
    logic        p2_valid_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p2_mx0_reg <= p1_num_reg[31:0] * p1_sb_reg.ax;
            p2_mx1_reg <= p1_num_reg[63:32] * p1_sb_reg.ax;
            p2_my0_reg <= p1_num_reg[31:0] * p1_sb_reg.ay;
            p2_my1_reg <= p1_num_reg[63:32] * p1_sb_reg.ay;
            p2_n2_reg  <= p1_num_reg[64];
            p2_sb_reg  <= p1_sb_reg;
        end
    end

    // P3: full products plus half of T for rounding
    logic [96:0] p3_px_reg, p3_py_reg;
    sqrt_sb_t    p3_sb_reg;
    logic        p3_valid_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p3_px_reg <= (p2_n2_reg ? {1'b0, p2_sb_reg.ax, 64'd0} : 97'd0)
                       + {1'b0, p2_mx1_reg, 32'd0} + {33'd0, p2_mx0_reg}
                       + {36'd0, p2_sb_reg.t[61:1]};
            p3_py_reg <= (p2_n2_reg ? {1'b0, p2_sb_reg.ay, 64'd0} : 97'd0)
                       + {1'b0, p2_my1_reg, 32'd0} + {33'd0, p2_my0_reg}
                       + {36'd0, p2_sb_reg.t[61:1]};
            p3_sb_reg <= p2_sb_reg;
        end
    end

    // P4: flag quotients that would not fit the divider
    logic [1:0][96:0] p4_num_reg;
    logic [61:0]      p4_t_reg;
    div_sb_t          p4_sb_reg;
    logic             p4_valid_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p4_num_reg[0]    <= p3_px_reg;
            p4_num_reg[1]    <= p3_py_reg;
            p4_t_reg         <= p3_sb_reg.t;
            p4_sb_reg.tx     <= p3_sb_reg.tx;
            p4_sb_reg.ty     <= p3_sb_reg.ty;
            p4_sb_reg.vx_neg <= p3_sb_reg.vx_neg;
            p4_sb_reg.vy_neg <= p3_sb_reg.vy_neg;
            p4_sb_reg.sat_x  <= (p3_px_reg >= {p3_sb_reg.t, 35'd0});
            p4_sb_reg.sat_y  <= (p3_py_reg >= {p3_sb_reg.t, 35'd0});
            p4_sb_reg.bypass <= p3_sb_reg.bypass;
        end
    end

    logic                      dv_valid;
    logic [1:0][DIV_STEPS-1:0] dv_quo;
    div_sb_t                   dv_sb;

    iap_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en_i    (pipe_en),
        .valid_i (p4_valid_reg),
        .num_i   (p4_num_reg),
        .den_i   (p4_t_reg),
        .sb_i    (p4_sb_reg),
        .valid_o (dv_valid),
        .quo_o   (dv_quo),
        .sb_o    (dv_sb)
    );

    // F1: saturate, apply sign, add to target position
    logic [DIV_STEPS-1:0] qx_next, qy_next;
    logic [35:0]          offx_next, offy_next;
    logic [35:0]          f1_sumx_reg, f1_sumy_reg;
    logic signed [31:0]   f1_tx_reg, f1_ty_reg;
    logic                 f1_bypass_reg;

    assign qx_next = (dv_sb.sat_x || (dv_quo[0] > OFFSET_CAP)) ? OFFSET_CAP : dv_quo[0];
    assign qy_next = (dv_sb.sat_y || (dv_quo[1] > OFFSET_CAP)) ? OFFSET_CAP : dv_quo[1];
    assign offx_next = dv_sb.vx_neg ? (36'd0 - {1'b0, qx_next}) : {1'b0, qx_next};
    assign offy_next = dv_sb.vy_neg ? (36'd0 - {1'b0, qy_next}) : {1'b0, qy_next};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            f1_sumx_reg   <= {{4{dv_sb.tx[31]}}, dv_sb.tx} + offx_next;
            f1_sumy_reg   <= {{4{dv_sb.ty[31]}}, dv_sb.ty} + offy_next;
            f1_tx_reg     <= dv_sb.tx;
            f1_ty_reg     <= dv_sb.ty;
            f1_bypass_reg <= dv_sb.bypass;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            p1_valid_reg <= sq_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            f1_valid_reg <= dv_valid;
        end
    end

    // output register: clamp a solved point, pass a target position through
    logic signed [35:0] clx_next, cly_next;
    logic signed [31:0] aim_x_next, aim_y_next;
    logic signed [31:0] aim_x_reg, aim_y_reg;
    logic               solved_reg;

    always_comb begin
        clx_next = $signed(f1_sumx_reg);
        if (clx_next > 36'(bound_right_reg)) clx_next = 36'(bound_right_reg);
        if (clx_next < 36'(bound_left_reg))  clx_next = 36'(bound_left_reg);
        cly_next = $signed(f1_sumy_reg);
        if (cly_next > 36'(bound_bottom_reg)) cly_next = 36'(bound_bottom_reg);
        if (cly_next < 36'(bound_top_reg))    cly_next = 36'(bound_top_reg);
        aim_x_next = f1_bypass_reg ? f1_tx_reg : clx_next[31:0];
        aim_y_next = f1_bypass_reg ? f1_ty_reg : cly_next[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            aim_x_reg  <= aim_x_next;
            aim_y_reg  <= aim_y_next;
            solved_reg <= !f1_bypass_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_aim_x  = aim_x_reg;
    assign m_aim_y  = aim_y_reg;
    assign m_solved = solved_reg;

    `IAP_ASSERT_NXT(a_last_stage_held, f1_valid_reg && !pipe_en, f1_valid_reg,
                    "last stage item dropped during stall")
    `IAP_ASSERT_IMP(a_aim_x_in_box,
                    m_valid_reg && solved_reg && (bound_left_reg <= bound_right_reg),
                    (aim_x_reg >= bound_left_reg) && (aim_x_reg <= bound_right_reg),
                    "solved aim x outside clamp rectangle")
    `IAP_ASSERT_IMP(a_aim_y_in_box,
                    m_valid_reg && solved_reg && (bound_top_reg <= bound_bottom_reg),
                    (aim_y_reg >= bound_top_reg) && (aim_y_reg <= bound_bottom_reg),
                    "solved aim y outside clamp rectangle")

endmodule
